// ----- rtl/htnm_pkg.sv -----
// Package for the height to normal map unit: word types, widths and pipeline constants.
// It depends on nothing else. The unit's top level uses it by scoped names.
package htnm_pkg;

    localparam int HEIGHT_W     = 8;
    localparam int DIFF_W       = 9;
    localparam int SUM_W        = 18;
    localparam int FRAC_BITS    = 20;
    localparam int ROOT_W       = 29;
    localparam int REM_W        = 32;
    localparam int SQRT_STAGES  = 29;
    localparam int NUM_W        = 30;
    localparam int DIVIDEND_W   = 38;
    localparam int DIV_W        = 39;
    localparam int QUOT_BITS    = 9;
    localparam int LANES        = 3;
    localparam int PIPE_LATENCY = SQRT_STAGES + QUOT_BITS + 3;

    localparam logic [DIFF_W-1:0] HEIGHT_FULL = 9'd255;
    localparam logic [SUM_W-1:0]  FULL_SQUARE = 18'd65025;
    localparam logic [ROOT_W-1:0] LEN_MIN     = ROOT_W'(255) << FRAC_BITS;
    localparam logic [HEIGHT_W-1:0] BYTE_MAX  = 8'd255;
    localparam logic [HEIGHT_W-1:0] BYTE_MID  = 8'd127;

    typedef struct packed {
        logic [HEIGHT_W-1:0] center_height;
        logic [HEIGHT_W-1:0] left_height;
        logic [HEIGHT_W-1:0] up_height;
    } pixel_word_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] normal_red;
        logic [HEIGHT_W-1:0] normal_green;
        logic [HEIGHT_W-1:0] normal_blue;
    } normal_word_t;

endpackage

// ----- rtl/height_to_normal_map_unit.sv -----
// Top level of the height to normal map unit: a fully pipelined normal generator.
// It depends on htnm_pkg for the word types and the pipeline constants.
//
//   channel  | handshake      | word
//   ---------+----------------+----------------------------------------
//   pixel    | start / busy   | center, left and up heights, 8 bits each
//   normal   | done (strobe)  | red, green and blue bytes of the normal
//
// A word is taken in every cycle that start is high; busy always stays low.
// Each normal leaves on done after its pixel has passed, in order, through one
// difference stage, 29 square root stages (one root bit each), one numerator
// stage, nine quotient stages (one quotient bit each, three lanes) and the output.
// Reset clears only the valid bits; a pixel in flight at reset is dropped.
// The receiver cannot stall, so the pipeline never holds.
module height_to_normal_map_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  htnm_pkg::pixel_word_t pixel,
    output logic                  done,
    output htnm_pkg::normal_word_t normal
);

    logic                              sq_valid_reg [0:htnm_pkg::SQRT_STAGES];
    logic signed [htnm_pkg::DIFF_W-1:0] sq_da_reg   [0:htnm_pkg::SQRT_STAGES];
    logic signed [htnm_pkg::DIFF_W-1:0] sq_db_reg   [0:htnm_pkg::SQRT_STAGES];
    logic [htnm_pkg::SUM_W-1:0]        sq_sum_reg   [0:htnm_pkg::SQRT_STAGES];
    logic [htnm_pkg::ROOT_W-1:0]       sq_root_reg  [0:htnm_pkg::SQRT_STAGES];
    logic [htnm_pkg::REM_W-1:0]        sq_rem_reg   [0:htnm_pkg::SQRT_STAGES];

    logic                              dv_valid_reg [0:htnm_pkg::QUOT_BITS];
    logic [htnm_pkg::NUM_W-1:0]        dv_div_reg   [0:htnm_pkg::QUOT_BITS];
    logic [htnm_pkg::DIV_W-1:0]        dv_rem_reg   [0:htnm_pkg::QUOT_BITS][0:htnm_pkg::LANES-1];
    logic [htnm_pkg::QUOT_BITS-1:0]    dv_q_reg     [0:htnm_pkg::QUOT_BITS][0:htnm_pkg::LANES-1];

    logic                   done_reg;
    htnm_pkg::normal_word_t normal_reg;
    htnm_pkg::normal_word_t normal_next;

    logic signed [htnm_pkg::DIFF_W-1:0] da_next;
    logic signed [htnm_pkg::DIFF_W-1:0] db_next;
    logic [htnm_pkg::SUM_W-1:0]        sum_next;
    logic [2*htnm_pkg::DIFF_W-1:0]     da_sq;
    logic [2*htnm_pkg::DIFF_W-1:0]     db_sq;

    assign busy = 1'b0;

    always_comb
    begin
        da_next  = $signed({1'b0, pixel.left_height}) - $signed({1'b0, pixel.center_height});
        db_next  = $signed({1'b0, pixel.up_height}) - $signed({1'b0, pixel.center_height});
        da_sq    = $unsigned((2*htnm_pkg::DIFF_W)'(da_next) * (2*htnm_pkg::DIFF_W)'(da_next));
        db_sq    = $unsigned((2*htnm_pkg::DIFF_W)'(db_next) * (2*htnm_pkg::DIFF_W)'(db_next));
        sum_next = da_sq + db_sq + htnm_pkg::FULL_SQUARE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else
        begin
            sq_valid_reg[0] <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_da_reg[0]   <= da_next;
        sq_db_reg[0]   <= db_next;
        sq_sum_reg[0]  <= sum_next;
        sq_root_reg[0] <= '0;
        sq_rem_reg[0]  <= '0;
    end

    for (genvar j = 0; j < htnm_pkg::SQRT_STAGES; j++)
    begin : gen_sqrt
        logic [1:0]                  pair;
        logic [htnm_pkg::REM_W-1:0]  rem_sh;
        logic [htnm_pkg::REM_W-1:0]  trial;
        logic                        ge;
        logic [htnm_pkg::ROOT_W-1:0] root_next;
        logic [htnm_pkg::REM_W-1:0]  rem_next;

        if (j < htnm_pkg::SUM_W / 2)
        begin : gen_pair
            assign pair = sq_sum_reg[j][2*(htnm_pkg::SUM_W/2-1-j) +: 2];
        end
        else
        begin : gen_zero
            assign pair = 2'b00;
        end

        always_comb
        begin
            rem_sh    = {sq_rem_reg[j][htnm_pkg::REM_W-3:0], pair};
            trial     = {1'b0, sq_root_reg[j], 2'b01};
            ge        = rem_sh >= trial;
            rem_next  = ge ? rem_sh - trial : rem_sh;
            root_next = {sq_root_reg[j][htnm_pkg::ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[j+1] <= 1'b0;
            end
            else
            begin
                sq_valid_reg[j+1] <= sq_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_da_reg[j+1]   <= sq_da_reg[j];
            sq_db_reg[j+1]   <= sq_db_reg[j];
            sq_sum_reg[j+1]  <= sq_sum_reg[j];
            sq_root_reg[j+1] <= root_next;
            sq_rem_reg[j+1]  <= rem_next;
        end
    end

    logic [htnm_pkg::ROOT_W-1:0] len;
    logic signed [htnm_pkg::DIFF_W-1:0] comp [0:htnm_pkg::LANES-1];
    logic [htnm_pkg::NUM_W:0]        num_s    [0:htnm_pkg::LANES-1];
    logic [htnm_pkg::NUM_W-1:0]      num      [0:htnm_pkg::LANES-1];
    logic [htnm_pkg::DIVIDEND_W-1:0] dividend [0:htnm_pkg::LANES-1];

    assign len = sq_root_reg[htnm_pkg::SQRT_STAGES];

    always_comb
    begin
        comp[0] = sq_da_reg[htnm_pkg::SQRT_STAGES];
        comp[1] = sq_db_reg[htnm_pkg::SQRT_STAGES];
        comp[2] = htnm_pkg::HEIGHT_FULL;
        for (int k = 0; k < htnm_pkg::LANES; k++)
        begin
            num_s[k] = {{(htnm_pkg::NUM_W + 1 - htnm_pkg::DIFF_W - htnm_pkg::FRAC_BITS)
                          {comp[k][htnm_pkg::DIFF_W-1]}},
                        comp[k], {htnm_pkg::FRAC_BITS{1'b0}}}
                     + {{(htnm_pkg::NUM_W + 1 - htnm_pkg::ROOT_W){1'b0}}, len};
            num[k] = num_s[k][htnm_pkg::NUM_W] ? '0 : num_s[k][htnm_pkg::NUM_W-1:0];
            dividend[k] = {num[k], 8'd0}
                        - {{(htnm_pkg::DIVIDEND_W - htnm_pkg::NUM_W){1'b0}}, num[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[0] <= sq_valid_reg[htnm_pkg::SQRT_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        dv_div_reg[0] <= {len, 1'b0};
        for (int k = 0; k < htnm_pkg::LANES; k++)
        begin
            dv_rem_reg[0][k] <= {1'b0, dividend[k]};
            dv_q_reg[0][k]   <= '0;
        end
    end

    for (genvar s = 0; s < htnm_pkg::QUOT_BITS; s++)
    begin : gen_div
        localparam int BIT = htnm_pkg::QUOT_BITS - 1 - s;

        logic [htnm_pkg::DIV_W-1:0]     shifted;
        logic [htnm_pkg::DIV_W-1:0]     rem_next [0:htnm_pkg::LANES-1];
        logic [htnm_pkg::QUOT_BITS-1:0] q_next   [0:htnm_pkg::LANES-1];

        always_comb
        begin
            shifted = {{(htnm_pkg::DIV_W - htnm_pkg::NUM_W){1'b0}}, dv_div_reg[s]} << BIT;
            for (int k = 0; k < htnm_pkg::LANES; k++)
            begin
                q_next[k] = dv_q_reg[s][k];
                if (dv_rem_reg[s][k] >= shifted)
                begin
                    rem_next[k]    = dv_rem_reg[s][k] - shifted;
                    q_next[k][BIT] = 1'b1;
                end
                else
                begin
                    rem_next[k] = dv_rem_reg[s][k];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[s+1] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[s+1] <= dv_valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_div_reg[s+1] <= dv_div_reg[s];
            for (int k = 0; k < htnm_pkg::LANES; k++)
            begin
                dv_rem_reg[s+1][k] <= rem_next[k];
                dv_q_reg[s+1][k]   <= q_next[k];
            end
        end
    end

    logic [htnm_pkg::HEIGHT_W-1:0] byte_out [0:htnm_pkg::LANES-1];

    always_comb
    begin
        for (int k = 0; k < htnm_pkg::LANES; k++)
        begin
            if (dv_q_reg[htnm_pkg::QUOT_BITS][k][htnm_pkg::QUOT_BITS-1])
            begin
                byte_out[k] = htnm_pkg::BYTE_MAX;
            end
            else
            begin
                byte_out[k] = dv_q_reg[htnm_pkg::QUOT_BITS][k][htnm_pkg::HEIGHT_W-1:0];
            end
        end
        normal_next.normal_red   = byte_out[0];
        normal_next.normal_green = byte_out[1];
        normal_next.normal_blue  = byte_out[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid_reg[htnm_pkg::QUOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        normal_reg <= normal_next;
    end

    assign done   = done_reg;
    assign normal = normal_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(htnm_pkg::PIPE_LATENCY) done)
        else $error("A taken pixel word did not produce a normal word on time.");

    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && pixel.left_height == pixel.center_height
        && pixel.up_height == pixel.center_height
        |-> ##(htnm_pkg::PIPE_LATENCY)
        normal.normal_red == htnm_pkg::BYTE_MID && normal.normal_green == htnm_pkg::BYTE_MID
        && normal.normal_blue == htnm_pkg::BYTE_MAX)
        else $error("A flat surface did not give the straight up normal.");

    assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid_reg[htnm_pkg::SQRT_STAGES] |-> len >= htnm_pkg::LEN_MIN)
        else $error("The normal length fell below its lower bound.");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> normal.normal_blue >= htnm_pkg::BYTE_MID)
        else $error("The z component of a normal came out negative.");
`endif

endmodule

// ----- verif/height_to_normal_map_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for height_to_normal_map_unit: random and directed pixel words
// are predicted in fixed point and compared with every normal word. Depends on htnm_pkg.

module height_to_normal_map_unit_test;

    typedef longint unsigned u64_t;
    typedef longint signed   s64_t;

    localparam int FULL_SCALE = 255;
    localparam int MAP_DIM    = 8;

    logic                   clk   = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    htnm_pkg::pixel_word_t  pixel = '0;
    logic                   busy;
    logic                   done;
    htnm_pkg::normal_word_t normal;

    htnm_pkg::pixel_word_t  pending_pixels[$];
    htnm_pkg::normal_word_t expected_normals[$];

    logic word_taken = 1'b0;
    int   idle_left = 0;
    int   steady_left = 0;
    int   mismatches = 0;
    int   normals_checked = 0;
    int   flat_words = 0;
    int   map_words = 0;
    int   maps_sent = 0;

    height_to_normal_map_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixel  (pixel),
        .done   (done),
        .normal (normal)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic u64_t floor_root(input u64_t value);
        u64_t rest;
        u64_t root;
        u64_t probe;
        rest  = value;
        root  = 0;
        probe = u64_t'(1) << 62;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic logic [htnm_pkg::HEIGHT_W-1:0] component_byte(input s64_t comp,
                                                                     input u64_t len);
        s64_t numer;
        u64_t quot;
        numer = comp * (s64_t'(1) << htnm_pkg::FRAC_BITS) + s64_t'(len);
        if (numer < 0)
            numer = 0;
        quot = (u64_t'(numer) * 255) / (2 * len);
        if (quot > 255)
            quot = 255;
        return quot[htnm_pkg::HEIGHT_W-1:0];
    endfunction

    function automatic htnm_pkg::normal_word_t predict_normal(input htnm_pkg::pixel_word_t word);
        s64_t                   dx;
        s64_t                   dy;
        u64_t                   square_sum;
        u64_t                   len;
        htnm_pkg::normal_word_t result;
        dx = s64_t'(word.left_height) - s64_t'(word.center_height);
        dy = s64_t'(word.up_height) - s64_t'(word.center_height);
        square_sum = u64_t'(dx * dx + dy * dy + FULL_SCALE * FULL_SCALE);
        len = floor_root(square_sum << (2 * htnm_pkg::FRAC_BITS));
        result.normal_red   = component_byte(dx, len);
        result.normal_green = component_byte(dy, len);
        result.normal_blue  = component_byte(FULL_SCALE, len);
        return result;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (steady_left > 0)
        begin
            steady_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            steady_left = $urandom_range(20, 80);
            return 0;
        end
        else if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic add_pixel(input int center, input int left, input int up);
        htnm_pkg::pixel_word_t word;
        word.center_height = center[htnm_pkg::HEIGHT_W-1:0];
        word.left_height   = left[htnm_pkg::HEIGHT_W-1:0];
        word.up_height     = up[htnm_pkg::HEIGHT_W-1:0];
        if (word.center_height == word.left_height && word.center_height == word.up_height)
            flat_words++;
        pending_pixels.push_back(word);
    endtask

    task automatic add_height_map(input int rows, input int cols, input int slope);
        int height_map[MAP_DIM][MAP_DIM];
        int level;
        level = $urandom_range(0, 255);
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                if (r > 0 && c == 0)
                    level = height_map[r-1][0];
                if ($urandom_range(0, 19) == 0)
                    level = $urandom_range(0, 255);
                else
                    level = level + $urandom_range(0, 2 * slope) - slope;
                if (level < 0)
                    level = 0;
                if (level > 255)
                    level = 255;
                height_map[r][c] = level;
            end
        end
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                add_pixel(height_map[r][c], height_map[r][(c + cols - 1) % cols],
                          height_map[(r + rows - 1) % rows][c]);
        map_words += rows * cols;
        maps_sent++;
    endtask

    always @(negedge clk)
    begin : drive
        logic next_start;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            next_start = 1'b0;
            if (start && word_taken)
            begin
                void'(pending_pixels.pop_front());
                idle_left = pick_gap();
            end
            if (start && !word_taken)
            begin
                next_start = 1'b1;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
            end
            else if (pending_pixels.size() > 0)
            begin
                next_start = 1'b1;
                pixel <= pending_pixels[0];
            end
            start <= next_start;
        end
    end

    always @(posedge clk)
    begin : watch
        htnm_pkg::normal_word_t want;
        if (!rst_n)
        begin
            word_taken = 1'b0;
        end
        else
        begin
            if (done)
            begin
                if (expected_normals.size() == 0)
                begin
                    $error("Normal word %h arrived with none expected.", normal);
                    mismatches++;
                end
                else
                begin
                    want = expected_normals.pop_front();
                    normals_checked++;
                    if (normal.normal_red !== want.normal_red)
                    begin
                        $error("normal_red: expected %0d, got %0d", want.normal_red,
                               normal.normal_red);
                        mismatches++;
                    end
                    if (normal.normal_green !== want.normal_green)
                    begin
                        $error("normal_green: expected %0d, got %0d", want.normal_green,
                               normal.normal_green);
                        mismatches++;
                    end
                    if (normal.normal_blue !== want.normal_blue)
                    begin
                        $error("normal_blue: expected %0d, got %0d", want.normal_blue,
                               normal.normal_blue);
                        mismatches++;
                    end
                end
            end
            word_taken = start && !busy;
            if (word_taken)
                expected_normals.push_back(predict_normal(pixel));
        end
    end

    initial
    begin
        int center;
        add_pixel(0, 0, 0);
        add_pixel(128, 128, 128);
        add_pixel(255, 255, 255);
        add_pixel(0, 255, 255);
        add_pixel(255, 0, 0);
        add_pixel(0, 255, 0);
        add_pixel(0, 0, 255);
        add_pixel(255, 0, 255);
        add_pixel(255, 255, 0);
        add_pixel(0, 255, 128);
        add_pixel(255, 128, 0);
        add_pixel(128, 0, 255);
        add_pixel(128, 255, 0);
        add_pixel(100, 101, 100);
        add_pixel(100, 100, 99);
        add_pixel(170, 85, 85);
        add_pixel(85, 170, 170);
        add_pixel(1, 2, 4);
        for (int m = 0; m < 4; m++)
            add_height_map($urandom_range(2, MAP_DIM), $urandom_range(2, MAP_DIM),
                           $urandom_range(1, 40));
        while (pending_pixels.size() < 500)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                add_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
            end
            else
            begin
                center = $urandom_range(0, 255);
                add_pixel(center,
                          (center + $urandom_range(0, 16) - 8) & 8'hFF,
                          (center + $urandom_range(0, 16) - 8) & 8'hFF);
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_pixels.size() == 0);
        wait (expected_normals.size() == 0);
        repeat (htnm_pkg::PIPE_LATENCY + 10) @(posedge clk);

        $display("Drove %0d pixel words, %0d of them flat and %0d from %0d wrapped height maps.",
                 normals_checked, flat_words, map_words, maps_sent);
        $display("Checked %0d normal words field by field.", normals_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d pixel words unsent and %0d normal words outstanding.",
                 pending_pixels.size(), expected_normals.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
